// ===== rtl/rgr_pkg.sv =====
// Shared types, constants and helpers for the windowed green-to-gold recolor block.
package rgr_pkg;

   // Fixed frame geometry.
   localparam int FRAME_WIDTH  = 360;
   localparam int FRAME_HEIGHT = 360;
   localparam int COL_W = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
   localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

   // Register file geometry.
   localparam int WIN_W       = 9;
   localparam int FLOOR_W     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   // Comparison widths wide enough for a counter and a window bound.
   localparam int COL_CMP_W = (COL_W > WIN_W) ? COL_W : WIN_W;
   localparam int ROW_CMP_W = (ROW_W > WIN_W) ? ROW_W : WIN_W;

   // RGB565 fields.
   localparam int PIX_W   = 16;
   localparam int RED_W   = 5;
   localparam int GREEN_W = 6;
   localparam int BLUE_W  = 5;

   // Gold color offsets and limits.
   localparam logic [6:0] GOLD_RED_BASE   = 7'd18;
   localparam logic [6:0] GOLD_GREEN_BASE = 7'd16;
   localparam logic [6:0] GOLD_BLUE_BASE  = 7'd2;
   localparam logic [6:0] RED_MAX         = 7'd31;
   localparam logic [6:0] GREEN_MAX       = 7'd63;
   localparam logic [6:0] BLUE_MAX        = 7'd31;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LEFT   = 3'd0,
      CSR_WINDOW_RIGHT  = 3'd1,
      CSR_WINDOW_TOP    = 3'd2,
      CSR_WINDOW_BOTTOM = 3'd3,
      CSR_GREEN_FLOOR   = 3'd4
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [WIN_W-1:0]   WINDOW_LEFT_RST   = 9'd45;
   localparam logic [WIN_W-1:0]   WINDOW_RIGHT_RST  = 9'd315;
   localparam logic [WIN_W-1:0]   WINDOW_TOP_RST    = 9'd55;
   localparam logic [WIN_W-1:0]   WINDOW_BOTTOM_RST = 9'd235;
   localparam logic [FLOOR_W-1:0] GREEN_FLOOR_RST   = 6'd18;

   typedef struct packed {
      logic [WIN_W-1:0]   window_left;
      logic [WIN_W-1:0]   window_right;
      logic [WIN_W-1:0]   window_top;
      logic [WIN_W-1:0]   window_bottom;
      logic [FLOOR_W-1:0] green_floor;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } pos_type;

   // green / 5 for a six-bit value: (g * 13) >> 6 is exact over 0..63.
   function automatic logic [3:0] div5_green(input logic [GREEN_W-1:0] g);
      logic [9:0] prod;
      prod = {4'd0, g} * 10'd13;
      return prod[9:6];
   endfunction

   function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] top);
      return (v > top) ? top : v;
   endfunction

endpackage

// ===== rtl/rgr_csr.sv =====
// Configuration register file: window bounds and green floor.
module rgr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgr_pkg::CSR_DATA_W-1:0]  csr_data,
   output rgr_pkg::cfg_type               cfg
);
   import rgr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LEFT:   cfg_in.window_left   = csr_data[WIN_W-1:0];
            CSR_WINDOW_RIGHT:  cfg_in.window_right  = csr_data[WIN_W-1:0];
            CSR_WINDOW_TOP:    cfg_in.window_top    = csr_data[WIN_W-1:0];
            CSR_WINDOW_BOTTOM: cfg_in.window_bottom = csr_data[WIN_W-1:0];
            CSR_GREEN_FLOOR:   cfg_in.green_floor   = csr_data[FLOOR_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_left   <= WINDOW_LEFT_RST;
         cfg_ff.window_right  <= WINDOW_RIGHT_RST;
         cfg_ff.window_top    <= WINDOW_TOP_RST;
         cfg_ff.window_bottom <= WINDOW_BOTTOM_RST;
         cfg_ff.green_floor   <= GREEN_FLOOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/rgr_position.sv =====
// Raster position tracker: column and row of the pixel being accepted.
module rgr_position (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             frame_start,
   output rgr_pkg::pos_type pos
);
   import rgr_pkg::*;

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;

   // Start of frame places this pixel at the origin.
   assign pos.col = frame_start ? '0 : col_ff;
   assign pos.row = frame_start ? '0 : row_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (pos.col == COL_W'(FRAME_WIDTH - 1)) begin
            col_in = '0;
            row_in = (pos.row == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : pos.row + ROW_W'(1);
         end else begin
            col_in = pos.col + COL_W'(1);
            row_in = pos.row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== rtl/rgr_recolor.sv =====
// Window test, green dominance test and gold color generation for one pixel.
module rgr_recolor (
   input  rgr_pkg::cfg_type               cfg,
   input  rgr_pkg::pos_type               pos,
   input  logic [rgr_pkg::PIX_W-1:0]      pixel_in,
   output logic [rgr_pkg::PIX_W-1:0]      pixel_out,
   output logic                           recolored
);
   import rgr_pkg::*;

   logic [RED_W-1:0]     red;
   logic [GREEN_W-1:0]   green;
   logic [BLUE_W-1:0]    blue;
   logic [COL_CMP_W-1:0] col_x;
   logic [ROW_CMP_W-1:0] row_x;
   logic                 in_window;
   logic [8:0]           green_x4;
   logic [8:0]           red_x10;
   logic [8:0]           blue_x10;
   logic                 dominant;
   logic [6:0]           gold_r;
   logic [6:0]           gold_g;
   logic [6:0]           gold_b;

   assign red   = pixel_in[15:11];
   assign green = pixel_in[10:5];
   assign blue  = pixel_in[4:0];

   assign col_x = COL_CMP_W'(pos.col);
   assign row_x = ROW_CMP_W'(pos.row);

   assign in_window = (col_x >= COL_CMP_W'(cfg.window_left)) &&
                      (col_x <  COL_CMP_W'(cfg.window_right)) &&
                      (row_x >= ROW_CMP_W'(cfg.window_top)) &&
                      (row_x <  ROW_CMP_W'(cfg.window_bottom));

   // green*4 against channel*10, all fit in nine bits
   assign green_x4 = {1'b0, green, 2'b00};
   assign red_x10  = {1'b0, red, 3'b000} + {3'b000, red, 1'b0};
   assign blue_x10 = {1'b0, blue, 3'b000} + {3'b000, blue, 1'b0};
   assign dominant = (green_x4 > red_x10) && (green_x4 > blue_x10);

   assign recolored = in_window && (green >= cfg.green_floor) && dominant;

   assign gold_r = clamp7(GOLD_RED_BASE + {3'd0, div5_green(green)}, RED_MAX);
   assign gold_g = clamp7(GOLD_GREEN_BASE + {2'd0, green[5:1]}, GREEN_MAX);
   assign gold_b = clamp7(GOLD_BLUE_BASE + {5'd0, green[5:4]}, BLUE_MAX);

   assign pixel_out = recolored ? {gold_r[RED_W-1:0], gold_g[GREEN_W-1:0], gold_b[BLUE_W-1:0]}
                                : pixel_in;

endmodule

// ===== rtl/windowed_green_to_gold_recolor_top.sv =====
// Top level of the windowed green-to-gold recolor block: handshakes and pipeline registers.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   req     | in        | req_valid/req_stall | req_pixel_in[15:0], req_frame_start
//   rsp     | out       | rsp_valid/rsp_stall | rsp_pixel_out[15:0], rsp_recolored
//   csr     | in        | csr_valid/csr_ready | csr_index[2:0], csr_data[8:0]
//
// One pixel per clock sustained while the result side does not stall. A pixel
// transfer lands in the input register, and the recolor logic sits between that
// register and the result register. Synchronous active-high reset
// clears both stage valids, the raster counters and the registers to defaults.
// A stalled result freezes the result register; the input register still takes
// one more pixel, and req_stall rises only when both stages hold data.
module windowed_green_to_gold_recolor_top (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rgr_pkg::PIX_W-1:0]       req_pixel_in,
   input  logic                            req_frame_start,
   // pixel result
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rgr_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic                            rsp_recolored,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rgr_pkg::*;

   cfg_type cfg;
   pos_type req_pos;

   // input stage
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [PIX_W-1:0]  s1_pixel_ff;
   pos_type           s1_pos_ff;

   // result stage
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pixel_ff;
   logic              rsp_recolored_ff;

   logic              rsp_free;
   logic              s1_move;
   logic              req_take;
   logic [PIX_W-1:0]  calc_pixel;
   logic              calc_hit;

   rgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Advance the raster counters on every pixel transfer.
   rgr_position u_position (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_take),
      .frame_start (req_frame_start),
      .pos         (req_pos)
   );

   rgr_recolor u_recolor (
      .cfg       (cfg),
      .pos       (s1_pos_ff),
      .pixel_in  (s1_pixel_ff),
      .pixel_out (calc_pixel),
      .recolored (calc_hit)
   );

   // The result register is free when empty or when its result leaves now.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && rsp_free;
   // Hold off the source only while the input register is full and stuck.
   assign req_stall = s1_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the pixel and its raster position on transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff <= req_pixel_in;
         s1_pos_ff   <= req_pos;
      end
   end

   // Load the result whenever the input stage moves forward; hold it otherwise.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_pixel_ff     <= calc_pixel;
         rsp_recolored_ff <= calc_hit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_recolored = rsp_recolored_ff;

endmodule

// ===== bench/tb_windowed_green_to_gold_recolor_top.sv =====
// Self-checking testbench for the windowed green-to-gold recolor block.
module tb_windowed_green_to_gold_recolor_top;
   import rgr_pkg::*;

   // Run limits: around a thousand pixels, far below the cycle limit.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PIXELS = 600;
   localparam int HOLD_CYCLES   = 64;
   localparam int DRAIN_CYCLES  = 6;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             recolored;
   } recolor_result_type;

   // Predicts the recolor from its own copy of the registers and raster position,
   // and holds the expected results in transfer order.
   class gold_recolor_scoreboard;
      logic [WIN_W-1:0]   left_edge, right_edge, top_edge, bottom_edge;
      logic [FLOOR_W-1:0] floor_level;
      int unsigned        col_pos, row_pos;
      recolor_result_type expected_pixels[$];
      int unsigned        mismatches, results_seen, gold_seen;

      function new();
         left_edge   = WINDOW_LEFT_RST;
         right_edge  = WINDOW_RIGHT_RST;
         top_edge    = WINDOW_TOP_RST;
         bottom_edge = WINDOW_BOTTOM_RST;
         floor_level = GREEN_FLOOR_RST;
         col_pos     = 0;
         row_pos     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_WINDOW_LEFT:   left_edge   = data;
            CSR_WINDOW_RIGHT:  right_edge  = data;
            CSR_WINDOW_TOP:    top_edge    = data;
            CSR_WINDOW_BOTTOM: bottom_edge = data;
            CSR_GREEN_FLOOR:   floor_level = data[FLOOR_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [PIX_W-1:0] pixel, logic frame_start);
         int unsigned        red, green, blue, gold_r, gold_g, gold_b;
         bit                 in_window;
         recolor_result_type entry;
         if (frame_start) begin
            col_pos = 0;
            row_pos = 0;
         end
         in_window = col_pos >= left_edge && col_pos < right_edge &&
                     row_pos >= top_edge && row_pos < bottom_edge;
         red   = pixel[15:11];
         green = pixel[10:5];
         blue  = pixel[4:0];
         entry.pixel     = pixel;
         entry.recolored = 1'b0;
         if (in_window && green >= floor_level &&
             green * 4 > red * 10 && green * 4 > blue * 10) begin
            gold_r = 18 + green / 5;
            gold_g = 16 + green / 2;
            gold_b = 2 + green / 16;
            if (gold_r > 31) gold_r = 31;
            if (gold_g > 63) gold_g = 63;
            if (gold_b > 31) gold_b = 31;
            entry.pixel     = {gold_r[4:0], gold_g[5:0], gold_b[4:0]};
            entry.recolored = 1'b1;
         end
         expected_pixels.push_back(entry);
         // advance the raster position, wrapping column into row and row into frame
         col_pos++;
         if (col_pos >= FRAME_WIDTH) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= FRAME_HEIGHT) row_pos = 0;
         end
      endfunction

      function void check_pixel(logic [PIX_W-1:0] pixel, logic recolored);
         recolor_result_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: pixel_out %h recolored %0b", pixel, recolored);
            return;
         end
         want = expected_pixels.pop_front();
         results_seen++;
         if (want.recolored) gold_seen++;
         if (pixel !== want.pixel || recolored !== want.recolored) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("wrong result %0d: pixel_out %h (want %h) recolored %0b (want %0b)",
                        results_seen, pixel, want.pixel, recolored, want.recolored);
         end
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic [PIX_W-1:0]       req_pixel_in    = '0;
   logic                   req_frame_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic                   rsp_recolored;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index       = '0;
   logic [CSR_DATA_W-1:0]  csr_data        = '0;

   gold_recolor_scoreboard recolor_board = new();

   // Shared knobs between the stimulus and the result side.
   bit          quiet        = 1'b0;  // suppress all idling on both channels
   bit          hold_pending = 1'b0;  // ask the result side for a long hold-off
   int          hold_left    = 0;
   int unsigned cycle_count  = 0;
   int unsigned pixels_sent  = 0;
   int unsigned writes_done  = 0;
   int unsigned settings     = 0;

   windowed_green_to_gold_recolor_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_recolored   (rsp_recolored),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: end the run as failed if the limit is reached.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, recolor_board.pending());
      $display("windowed_green_to_gold_recolor_top: mismatch");
      $finish;
   end

   // Result side: sample each transfer at the rising edge, then pick the next
   // stall value at the falling edge. A requested hold-off is counted here so
   // the sender keeps offering pixels and the block backs up into req_stall.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            recolor_board.check_pixel(rsp_pixel_out, rsp_recolored);
         @(negedge clock);
         if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 12);
         end
      end
   end

   // Offer one pixel and hold it until the transfer; note it when it goes in.
   task automatic send_pixel(logic [PIX_W-1:0] pixel, logic frame_start);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_pixel_in    <= pixel;
      req_frame_start <= frame_start;
      do @(posedge clock); while (req_stall);
      recolor_board.note_pixel(pixel, frame_start);
      pixels_sent++;
   endtask

   task automatic pause_input(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic maybe_pause();
      if (!quiet && $urandom_range(0, 99) < 12) pause_input($urandom_range(1, 4));
   endtask

   // Drop valid and wait until every expected result has come, then wait out
   // DRAIN_CYCLES, so the block is idle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (recolor_board.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      recolor_board.write_register(index, data);
      writes_done++;
   endtask

   // Write the whole register set; sometimes add a write to an unused index,
   // which must leave everything as it was.
   task automatic apply_window(logic [WIN_W-1:0] left_col, logic [WIN_W-1:0] right_col,
                               logic [WIN_W-1:0] top_row, logic [WIN_W-1:0] bottom_row,
                               logic [FLOOR_W-1:0] floor_level, bit add_unused);
      write_register(CSR_WINDOW_LEFT, left_col);
      write_register(CSR_WINDOW_RIGHT, right_col);
      write_register(CSR_WINDOW_TOP, top_row);
      write_register(CSR_WINDOW_BOTTOM, bottom_row);
      write_register(CSR_GREEN_FLOOR, CSR_DATA_W'(floor_level));
      if (add_unused)
         write_register(CSR_INDEX_W'(CSR_GREEN_FLOOR) + CSR_INDEX_W'($urandom_range(1, 3)),
                        CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_valid <= 1'b0;
      settings++;
   endtask

   // Window bound: mostly in range lo..hi, sometimes zero, the frame width or the register's maximum.
   function automatic logic [WIN_W-1:0] pick_bound(int lo, int hi);
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 2))
            0: return '0;
            1: return WIN_W'(FRAME_WIDTH);
            default: return '1;
         endcase
      end
      return WIN_W'($urandom_range(lo, hi));
   endfunction

   // Half the pixels are green-dominant, some sit on the dominance boundary,
   // the rest are arbitrary.
   function automatic logic [PIX_W-1:0] pick_pixel();
      int unsigned kind, red, green, blue, k, t;
      kind  = $urandom_range(0, 9);
      green = $urandom_range(0, 63);
      if (kind < 5) begin
         red  = (green == 0) ? 0 : $urandom_range(0, (green * 4 - 1) / 10);
         blue = (green == 0) ? 0 : $urandom_range(0, (green * 4 - 1) / 10);
      end else if (kind < 7) begin
         // green*4 equal to the other channel*10, or one step inside it
         k     = $urandom_range(0, 12);
         green = 5 * k;
         red   = 2 * k - ((k > 0 && $urandom_range(0, 1)) ? 1 : 0);
         blue  = (k == 0) ? 0 : $urandom_range(0, (green * 4 - 1) / 10);
         if ($urandom_range(0, 1)) begin
            t    = red;
            red  = blue;
            blue = t;
         end
      end else begin
         return PIX_W'($urandom);
      end
      return {red[4:0], green[5:0], blue[4:0]};
   endfunction

   initial begin
      int unsigned random_pixels, budget, sent, frame_len;
      bit          lead_start, start;

      random_pixels = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: row 0 lies above the default window, so nothing recolors.
      send_pixel(16'h07E0, 1'b1);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      drain_results();

      // Whole frame as window, floor 0: dominance edges and field extremes.
      apply_window(0, WIN_W'(FRAME_WIDTH), 0, WIN_W'(FRAME_HEIGHT), 0, 1'b1);
      send_pixel(16'h0000, 1'b1);  // green 0 never dominates
      send_pixel(16'h07E0, 1'b0);  // full green
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h08A1, 1'b0);  // green 5 over red 1 and blue 1
      send_pixel(16'h10A0, 1'b0);  // red exactly on the edge
      send_pixel(16'h00A2, 1'b0);  // blue exactly on the edge
      send_pixel(16'h07FF, 1'b0);
      send_pixel(16'hF800, 1'b0);
      drain_results();

      // Narrow window at columns 2..3 with the highest floor.
      apply_window(2, 4, 0, 1, 6'd63, 1'b0);
      send_pixel(16'h07E0, 1'b1);
      repeat (5) send_pixel(16'h07E0, 1'b0);
      send_pixel(16'h07C0, 1'b1);  // green 62 stays below the floor
      send_pixel(16'h07C0, 1'b0);
      send_pixel(16'h07C0, 1'b0);
      drain_results();

      // Inverted columns and an empty row range: nothing may recolor.
      apply_window(10, 5, 5, 5, 0, 1'b0);
      send_pixel(16'h07E0, 1'b1);
      repeat (3) send_pixel(16'h07E0, 1'b0);
      drain_results();

      // Random phases: frames near the top of the raster so the small windows
      // are reached, with some long frames that cross a row boundary. A few
      // stray frame starts and frames with no start break the sequence.
      while (random_pixels < RANDOM_PIXELS) begin
         apply_window(pick_bound(0, 40), pick_bound(10, 80), pick_bound(0, 1),
                      pick_bound(1, 3), ($urandom_range(0, 99) < 15) ?
                      (($urandom_range(0, 1)) ? 6'd63 : 6'd0) :
                      FLOOR_W'($urandom_range(0, 30)), $urandom_range(0, 3) == 0);
         budget = $urandom_range(100, 400);
         sent   = 0;
         // back up the block once while the sender keeps going
         if (settings == 4) hold_pending = 1'b1;
         while (sent < budget) begin
            frame_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(355, 420) :
                         $urandom_range(4, 60);
            lead_start = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < frame_len; i++) begin
               start = (i == 0 && lead_start) || ($urandom_range(0, 49) == 0);
               maybe_pause();
               send_pixel(pick_pixel(), start);
               sent++;
               random_pixels++;
               // once, let every result come home mid-phase
               if (settings == 4 && sent == budget / 2) drain_results();
            end
         end
         drain_results();
      end

      // A run with no idling and only the first frame start, long enough for the
      // column counter to wrap into the next row; the window sits at the origin.
      apply_window(0, 2, 0, 1, 0, 1'b0);
      quiet = 1'b1;
      for (int n = 0; n < FRAME_WIDTH + 8; n++)
         send_pixel(pick_pixel(), n == 0);
      quiet = 1'b0;
      drain_results();

      $display("Checked %0d pixels (%0d turned gold) across %0d window settings, %0d writes.",
               recolor_board.results_seen, recolor_board.gold_seen, settings, writes_done);
      $display("Included stalls, a long output hold-off and an unbroken run across a row.");
      if (recolor_board.mismatches == 0 && recolor_board.pending() == 0) begin
         $display("windowed_green_to_gold_recolor_top: match");
      end else begin
         $display("%0d wrong results, %0d still expected",
                  recolor_board.mismatches, recolor_board.pending());
         $display("windowed_green_to_gold_recolor_top: mismatch");
      end
      $finish;
   end

endmodule
